// ===== design/trace_step_controller_top_assert.svh =====
// assertion macros for the trace step controller
// clocked on i_clk with synchronous active-low i_rst_n of the using module
`ifndef TRACE_STEP_CONTROLLER_TOP_ASSERT_SVH
`define TRACE_STEP_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TSC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tsc assertion failed");
`define TSC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("tsc assertion failed");
`else
`define TSC_ASSERT(label, prop)
`define TSC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/tsc_pkg.sv =====
// types, codes and constants shared by the trace step controller
// no dependencies
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int unsigned MAX_INSTR_LIMIT = 1048576;
    localparam int CNT_W = 31;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_STEP_IN   = 4'd1,
        MODE_STEP_OUT  = 4'd2,
        MODE_PROC_IN   = 4'd3,
        MODE_PROC_OUT  = 4'd4,
        MODE_STEP_CNT  = 4'd5,
        MODE_PROC_CNT  = 4'd6,
        MODE_STEP_COND = 4'd7,
        MODE_PROC_COND = 4'd8,
        MODE_RET       = 4'd9,
        MODE_RECOVER   = 4'd10
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STEP = 2'd1,
        ACT_OVER = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_TRACE_MODE  = 2'd0,
        CFG_RANGE_START = 2'd1,
        CFG_RANGE_END   = 2'd2,
        CFG_STEP_COUNT  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_ARM  = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_RET_IMM  = 8'hC2;
    localparam logic [7:0] OP_RETF     = 8'hCB;
    localparam logic [7:0] OP_RETF_IMM = 8'hCA;
    localparam logic [7:0] OP_IRET     = 8'hCF;

    typedef struct packed {
        logic [3:0]       trace_mode;
        logic [31:0]      range_start;
        logic [31:0]      range_end;
        logic [CNT_W-1:0] step_count;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] exec_address;
        logic [7:0]  opcode_byte;
        logic        opcode_ok;
        logic        condition_met;
    } t_item;

    typedef struct packed {
        logic    handled;
        t_action next_action;
        logic    limit_hit;
    } t_result;

    function automatic logic is_ret_opcode(input logic [7:0] op);
        return op == OP_RET || op == OP_RET_IMM || op == OP_RETF ||
               op == OP_RETF_IMM || op == OP_IRET;
    endfunction

endpackage

// ===== design/trace_step_controller_top.sv =====
// Trace step controller: one result beat for every input beat.
// An accepted beat is held in the input register; its result moves into the result register when the held beat fires.
// Throughput: one beat per cycle while i_out_ready holds; set by the mode/counter update loop.
// Reset (synchronous, i_rst_n low): config registers zero, mode idle, counter zero,
// both pipeline registers empty.
// depends on tsc_pkg, tsc_cfg_regs and tsc_step_core
`timescale 1ns / 1ps

module trace_step_controller_top import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_exec_address,
    input  logic [7:0]  i_opcode_byte,
    input  logic        i_opcode_ok,
    input  logic        i_condition_met,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_handled,
    output logic [1:0]  o_next_action,
    output logic        o_limit_hit
);

    t_cfg    w_cfg;
    t_result w_res;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    logic    w_fire;

    tsc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tsc_step_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // process the held beat whenever the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{cmd: i_cmd, exec_address: i_exec_address,
                        opcode_byte: i_opcode_byte, opcode_ok: i_opcode_ok,
                        condition_met: i_condition_met};
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_handled     = r_res.handled;
    assign o_next_action = r_res.next_action;
    assign o_limit_hit   = r_res.limit_hit;

endmodule

// ===== design/tsc_cfg_regs.sv =====
// configuration register bank of the trace step controller
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_cfg_regs import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRACE_MODE:  n_cfg.trace_mode  = i_cfg_data[3:0];
                CFG_RANGE_START: n_cfg.range_start = i_cfg_data;
                CFG_RANGE_END:   n_cfg.range_end   = i_cfg_data;
                CFG_STEP_COUNT:  n_cfg.step_count  = i_cfg_data[CNT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/tsc_step_core.sv =====
// trace mode state, step counter and the per-step stop decision
// depends on tsc_pkg and trace_step_controller_top_assert.svh
`timescale 1ns / 1ps
`include "trace_step_controller_top_assert.svh"

module tsc_step_core import tsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_mode            r_mode;
    t_mode            n_mode;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_result          w_res;
    logic             w_inside;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_lim;

    localparam logic [CNT_W-1:0] C_LIMIT = CNT_W'(MAX_INSTR_LIMIT);

    assign w_inside  = (i_item.exec_address >= i_cfg.range_start) &&
                       (i_item.exec_address < i_cfg.range_end);
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_lim     = w_cnt_inc >= C_LIMIT;

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        w_res  = '{handled: 1'b0, next_action: ACT_NONE, limit_hit: 1'b0};
        if (t_cmd'(i_item.cmd) == CMD_ARM) begin
            // undefined codes arm as idle
            n_mode = (i_cfg.trace_mode > 4'(MODE_RECOVER)) ? MODE_IDLE
                                                          : t_mode'(i_cfg.trace_mode);
            if (n_mode == MODE_STEP_CNT || n_mode == MODE_PROC_CNT) begin
                n_cnt = i_cfg.step_count;
            end else begin
                n_cnt = '0;
            end
        end else begin
            case (r_mode)
                MODE_STEP_IN, MODE_PROC_IN, MODE_STEP_OUT, MODE_PROC_OUT: begin
                    if (w_inside == (r_mode == MODE_STEP_IN || r_mode == MODE_PROC_IN)) begin
                        n_mode        = MODE_IDLE;
                        n_cnt         = '0;
                        w_res.handled = 1'b1;
                    end else begin
                        w_res.next_action = (r_mode == MODE_STEP_IN || r_mode == MODE_STEP_OUT)
                                            ? ACT_STEP : ACT_OVER;
                    end
                end
                MODE_STEP_CNT, MODE_PROC_CNT: begin
                    // counter never goes negative, so stop when it was zero or one
                    if (r_cnt <= CNT_W'(1)) begin
                        n_mode        = MODE_IDLE;
                        n_cnt         = '0;
                        w_res.handled = 1'b1;
                    end else begin
                        n_cnt             = r_cnt - CNT_W'(1);
                        w_res.next_action = (r_mode == MODE_STEP_CNT) ? ACT_STEP : ACT_OVER;
                    end
                end
                MODE_STEP_COND, MODE_PROC_COND, MODE_RET: begin
                    if ((r_mode == MODE_RET) ? (i_item.opcode_ok &&
                                                is_ret_opcode(i_item.opcode_byte))
                                             : i_item.condition_met) begin
                        n_mode        = MODE_IDLE;
                        n_cnt         = '0;
                        w_res.handled = 1'b1;
                    end else if (w_lim) begin
                        n_mode          = MODE_IDLE;
                        n_cnt           = '0;
                        w_res.limit_hit = 1'b1;
                    end else begin
                        n_cnt             = w_cnt_inc;
                        w_res.next_action = (r_mode == MODE_STEP_COND) ? ACT_STEP : ACT_OVER;
                    end
                end
                MODE_RECOVER: begin
                    n_mode = MODE_IDLE;
                    n_cnt  = '0;
                end
                default: begin
                    n_mode        = MODE_IDLE;
                    n_cnt         = '0;
                    w_res.handled = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

    assign o_result = w_res;

    // a stop or a give-up always leaves the block idle
    `TSC_ASSERT(a_stop_goes_idle,
        (i_fire && (w_res.handled || w_res.limit_hit)) |=> (r_mode == MODE_IDLE))
    // idle always carries a cleared counter
    `TSC_ASSERT(a_idle_cnt_clear, (r_mode == MODE_IDLE) |-> (r_cnt == '0))
    // limit only trips in the up-counting modes
    `TSC_ASSERT(a_limit_mode,
        w_res.limit_hit |-> (r_mode == MODE_STEP_COND || r_mode == MODE_PROC_COND ||
                             r_mode == MODE_RET))
    // up-counting modes stay below the limit
    `TSC_ASSERT(a_cnt_below_limit,
        (r_mode == MODE_STEP_COND || r_mode == MODE_PROC_COND || r_mode == MODE_RET)
        |-> (r_cnt < C_LIMIT))

endmodule

// ===== tb/tb_top.sv =====
// testbench for trace_step_controller_top: directed and random trace sequences,
// checked beat by beat against an in-bench model of the mode and counter logic
// depends on tsc_pkg and trace_step_controller_top
`timescale 1ns / 1ps

module tb_top;
    import tsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 1450;
    localparam int unsigned DRAIN_CYCLES  = 6;
    localparam logic [3:0]  MODE_UNDEF_LO = 4'd11;
    localparam logic [3:0]  MODE_UNDEF_HI = 4'd15;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        cmd = 1'b0;
    logic [31:0] exec_address = '0;
    logic [7:0]  opcode_byte = '0;
    logic        opcode_ok = 1'b0;
    logic        condition_met = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_handled;
    logic [1:0]  o_next_action;
    logic        o_limit_hit;

    // shadow of the config registers and the trace state
    logic [3:0]  cfg_mode = '0;
    logic [31:0] cfg_lo = '0;
    logic [31:0] cfg_hi = '0;
    logic [30:0] cfg_steps = '0;
    t_mode       trc_mode = MODE_IDLE;
    logic [31:0] trc_counter = '0;

    t_result     expected_verdicts[$];
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned verdicts_checked = 0;
    int unsigned trace_stops = 0;
    int unsigned limit_aborts = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_req = 0;
    int unsigned stall_left = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    trace_step_controller_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (cmd),
        .i_exec_address  (exec_address),
        .i_opcode_byte   (opcode_byte),
        .i_opcode_ok     (opcode_ok),
        .i_condition_met (condition_met),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_handled       (o_handled),
        .o_next_action   (o_next_action),
        .o_limit_hit     (o_limit_hit)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int unsigned random_gap();
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the trace state by one beat and return the verdict it should produce
    function automatic t_result next_verdict(input t_cmd c, input logic [31:0] addr,
                                             input logic [7:0] op, input logic ok,
                                             input logic cnd);
        t_result r;
        logic    inside_range;
        logic    stop;
        r.handled     = 1'b0;
        r.next_action = ACT_NONE;
        r.limit_hit   = 1'b0;
        if (c == CMD_ARM) begin
            trc_mode = (cfg_mode > 4'(MODE_RECOVER)) ? MODE_IDLE : t_mode'(cfg_mode);
            trc_counter = (trc_mode == MODE_STEP_CNT || trc_mode == MODE_PROC_CNT) ?
                          {1'b0, cfg_steps} : 32'd0;
            return r;
        end
        inside_range = addr >= cfg_lo && addr < cfg_hi;
        stop = 1'b0;
        case (trc_mode)
            MODE_STEP_IN, MODE_STEP_OUT, MODE_PROC_IN, MODE_PROC_OUT: begin
                if (inside_range == (trc_mode == MODE_STEP_IN || trc_mode == MODE_PROC_IN))
                    stop = 1'b1;
                else
                    r.next_action = (trc_mode == MODE_STEP_IN || trc_mode == MODE_STEP_OUT) ?
                                    ACT_STEP : ACT_OVER;
            end
            MODE_STEP_CNT, MODE_PROC_CNT: begin
                // counter is signed: zero or negative ends the trace
                trc_counter = trc_counter - 32'd1;
                if (trc_counter == 32'd0 || trc_counter[31])
                    stop = 1'b1;
                else
                    r.next_action = (trc_mode == MODE_STEP_CNT) ? ACT_STEP : ACT_OVER;
            end
            MODE_STEP_COND, MODE_PROC_COND, MODE_RET: begin
                if (trc_mode == MODE_RET ?
                    (ok && (op == OP_RET || op == OP_RET_IMM || op == OP_RETF ||
                            op == OP_RETF_IMM || op == OP_IRET)) : cnd) begin
                    stop = 1'b1;
                end else begin
                    trc_counter = trc_counter + 32'd1;
                    if (trc_counter >= MAX_INSTR_LIMIT) begin
                        trc_mode    = MODE_IDLE;
                        trc_counter = '0;
                        r.limit_hit = 1'b1;
                    end else begin
                        r.next_action = (trc_mode == MODE_STEP_COND) ? ACT_STEP : ACT_OVER;
                    end
                end
            end
            MODE_RECOVER: begin
                trc_mode    = MODE_IDLE;
                trc_counter = '0;
            end
            default: stop = 1'b1;
        endcase
        if (stop) begin
            trc_mode    = MODE_IDLE;
            trc_counter = '0;
            r.handled   = 1'b1;
        end
        return r;
    endfunction

    // result side: check each beat, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_verdicts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: handled %0d action %0d limit %0d",
                             o_handled, o_next_action, o_limit_hit);
            end else begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (want.handled) trace_stops++;
                if (want.limit_hit) limit_aborts++;
                if (o_handled !== want.handled || o_next_action !== want.next_action ||
                    o_limit_hit !== want.limit_hit) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected handled %0d action %0d limit %0d, got %0d %0d %0d",
                                 verdicts_checked, want.handled, want.next_action,
                                 want.limit_hit, o_handled, o_next_action, o_limit_hit);
                end
            end
        end
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
            out_ready <= 1'b0;
            stall_left = random_gap() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input t_cmd c, input logic [31:0] addr, input logic [7:0] op,
                             input logic ok, input logic cnd);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? random_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        exec_address  <= addr;
        opcode_byte   <= op;
        opcode_ok     <= ok;
        condition_met <= cnd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_verdicts.push_back(next_verdict(c, addr, op, ok, cnd));
        items_sent++;
    endtask

    task automatic drain_idle();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // registers only change with nothing in flight
    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        drain_idle();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TRACE_MODE:  cfg_mode  = data[3:0];
            CFG_RANGE_START: cfg_lo    = data;
            CFG_RANGE_END:   cfg_hi    = data;
            CFG_STEP_COUNT:  cfg_steps = data[30:0];
            default: ;
        endcase
    endtask

    task automatic rearm(input logic [3:0] mode);
        drain_idle();
        cfg_write(CFG_TRACE_MODE, {28'd0, mode});
        send_item(CMD_ARM, $urandom(), 8'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    task automatic step(input logic [31:0] addr, input logic [7:0] op, input logic ok,
                        input logic cnd);
        send_item(CMD_STEP, addr, op, ok, cnd);
    endtask

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 7))
            0, 1:    return cfg_lo - 32'd2 + 32'($urandom_range(0, 4));
            2, 3:    return cfg_hi - 32'd2 + 32'($urandom_range(0, 4));
            4:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 19))
            0:       return OP_RET;
            1:       return OP_RET_IMM;
            2:       return OP_RETF;
            3:       return OP_RETF_IMM;
            4:       return OP_IRET;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic test_idle_and_range();
        // step with nothing armed stops at once
        step(32'h0, 8'h90, 1'b1, 1'b0);
        cfg_write(CFG_RANGE_START, 32'h0000_1000);
        cfg_write(CFG_RANGE_END, 32'h0000_2000);
        rearm(MODE_STEP_IN);
        step(32'hFFFF_FFFF, 8'h90, 1'b1, 1'b0);
        step(32'h0000_2000, 8'h90, 1'b1, 1'b0);   // end bound is exclusive
        step(32'h0000_1000, 8'h90, 1'b1, 1'b0);
        rearm(MODE_PROC_OUT);
        step(32'h0000_1FFF, 8'h90, 1'b1, 1'b0);
        step(32'h0000_0000, 8'h90, 1'b1, 1'b0);
        rearm(MODE_STEP_OUT);
        step(32'h0000_0FFF, 8'h90, 1'b1, 1'b0);
        rearm(MODE_PROC_IN);
        step(32'h0000_1800, 8'h90, 1'b1, 1'b0);
    endtask

    task automatic test_count_modes();
        cfg_write(CFG_STEP_COUNT, 32'd0);         // wraps negative on the first step
        rearm(MODE_STEP_CNT);
        step($urandom(), 8'h90, 1'b1, 1'b0);
        drain_idle();
        cfg_write(CFG_STEP_COUNT, 32'd1);
        rearm(MODE_PROC_CNT);
        step($urandom(), 8'h90, 1'b1, 1'b0);
        drain_idle();
        cfg_write(CFG_STEP_COUNT, 32'h7FFF_FFFF);
        rearm(MODE_STEP_CNT);
        step($urandom(), 8'h90, 1'b1, 1'b1);
        step($urandom(), 8'h90, 1'b1, 1'b0);
    endtask

    task automatic test_condition_and_return();
        rearm(MODE_STEP_COND);
        step($urandom(), OP_RET, 1'b1, 1'b0);
        step($urandom(), 8'h90, 1'b1, 1'b1);
        rearm(MODE_PROC_COND);
        step($urandom(), 8'h90, 1'b0, 1'b1);
        rearm(MODE_RET);
        // unreadable return opcodes only count
        step($urandom(), OP_RET, 1'b0, 1'b1);
        step($urandom(), OP_RET_IMM, 1'b0, 1'b0);
        step($urandom(), OP_RETF, 1'b0, 1'b0);
        step($urandom(), OP_RETF_IMM, 1'b0, 1'b0);
        step($urandom(), OP_IRET, 1'b1, 1'b0);
    endtask

    task automatic test_recover_and_undefined();
        rearm(MODE_RECOVER);
        step($urandom(), 8'h90, 1'b1, 1'b0);
        step($urandom(), 8'h90, 1'b1, 1'b0);
        rearm(MODE_UNDEF_LO);
        step($urandom(), 8'h90, 1'b1, 1'b0);
        rearm(MODE_UNDEF_HI);
        step($urandom(), OP_RET, 1'b1, 1'b1);
        rearm(MODE_IDLE);
        step($urandom(), 8'h90, 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        drain_idle();
        cfg_write(CFG_STEP_COUNT, 32'd1000);
        rearm(MODE_PROC_CNT);
        tx_gaps_on = 1'b0;
        hold_req   = 300;
        repeat (40) step(pick_address(), pick_opcode(), 1'b1, 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traces();
        int unsigned random_items;
        int unsigned len;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [3:0]  mode;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain_idle();
            tx_gaps_on = $urandom_range(0, 4) != 0;
            rx_gaps_on = $urandom_range(0, 4) != 0;
            if ($urandom_range(0, 2) != 0) begin
                lo = $urandom();
                case ($urandom_range(0, 4))
                    0, 1: hi = lo + 32'($urandom_range(1, 64));
                    2:    begin lo = 32'h0; hi = 32'hFFFF_FFFF; end
                    3:    hi = lo;                                  // empty range
                    default: hi = $urandom();
                endcase
                cfg_write(CFG_RANGE_START, lo);
                cfg_write(CFG_RANGE_END, hi);
            end
            case ($urandom_range(0, 5))
                0:       cfg_write(CFG_STEP_COUNT, $urandom());
                1:       cfg_write(CFG_STEP_COUNT, 32'h7FFF_FFFF);
                default: cfg_write(CFG_STEP_COUNT, $urandom_range(0, 12));
            endcase
            mode = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 10)) :
                                                 4'($urandom_range(0, 15));
            rearm(mode);
            len = $urandom_range(1, 24);
            repeat (len) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(CMD_ARM, $urandom(), 8'($urandom()), 1'($urandom()),
                              1'($urandom()));
                else
                    step(pick_address(), pick_opcode(), $urandom_range(0, 4) != 0,
                         $urandom_range(0, 5) == 0);
                random_items++;
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        test_idle_and_range();
        test_count_modes();
        test_condition_and_return();
        test_recover_and_undefined();
        test_backpressure();
        test_random_traces();
        drain_idle();
        repeat (20) @(posedge i_clk);
        $display("tb_top: %0d beats sent, %0d results checked", items_sent, verdicts_checked);
        $display("tb_top: %0d trace stops, %0d instruction limit aborts",
                 trace_stops, limit_aborts);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/tsc_pkg.sv
design/tsc_cfg_regs.sv
design/tsc_step_core.sv
design/trace_step_controller_top.sv
tb/tb_top.sv
